// ===== src/shiprr_pkg.sv =====
`default_nettype none
package shiprr_pkg;

  localparam int DEF_NUM_SETS = 2048;
  localparam int DEF_NUM_WAYS = 16;
  localparam int DEF_SIG_SIZE = 4096;

  localparam int ADDR_W   = 64;
  localparam int SETIN_W  = 11;
  localparam int WAYIN_W  = 4;
  localparam int VICT_W   = 4;
  localparam int THR_W    = 2;
  localparam int RRPV_W   = 2;
  localparam int CTR_W    = 2;
  localparam int STRIDE_W = 8;
  localparam int SCORE_W  = 2;

  localparam int BLOCK_SHIFT = 6;
  localparam int HASH_SH_LO  = 2;
  localparam int HASH_SH_HI  = 10;

  localparam logic [RRPV_W-1:0]  RRPV_MAX   = 2'd3;
  localparam logic [RRPV_W-1:0]  RRPV_LONG  = 2'd2;
  localparam logic [RRPV_W-1:0]  RRPV_NEAR  = 2'd0;
  localparam logic [CTR_W-1:0]   CTR_MAX    = 2'd3;
  localparam logic [CTR_W-1:0]   CTR_RESET  = 2'd1;
  localparam logic [CTR_W-1:0]   CTR_STRONG = 2'd2;
  localparam logic [THR_W-1:0]   THR_RESET  = 2'd2;
  localparam logic [SCORE_W-1:0] SCORE_MAX  = 2'd3;

  localparam logic OP_VICTIM = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

endpackage
`default_nettype wire

// ===== src/shiprr_req_if.sv =====
`default_nettype none
interface shiprr_req_if import shiprr_pkg::*;;
  logic              valid;
  logic              ready;
  logic              op;
  logic [SETIN_W-1:0] set_index;
  logic [WAYIN_W-1:0] way_index;
  logic [ADDR_W-1:0]  phys_addr;
  logic [ADDR_W-1:0]  pc;
  logic              hit;

  modport source (output valid, op, set_index, way_index, phys_addr, pc, hit,
                  input ready);
  modport sink (input valid, op, set_index, way_index, phys_addr, pc, hit,
                output ready);
endinterface
`default_nettype wire

// ===== src/shiprr_rsp_if.sv =====
`default_nettype none
interface shiprr_rsp_if import shiprr_pkg::*;;
  logic              valid;
  logic              ready;
  logic [VICT_W-1:0] victim_way;
  logic              set_streaming;

  modport source (output valid, victim_way, set_streaming, input ready);
  modport sink (input valid, victim_way, set_streaming, output ready);
endinterface
`default_nettype wire

// ===== src/shiprr_front.sv =====
`default_nettype none
module shiprr_front import shiprr_pkg::*; #(
  parameter int NUM_SETS       = DEF_NUM_SETS,
  parameter int NUM_WAYS       = DEF_NUM_WAYS,
  parameter int SIG_TABLE_SIZE = DEF_SIG_SIZE,
  localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1,
  localparam int WAY_W = $clog2(NUM_WAYS),
  localparam int SIG_W = $clog2(SIG_TABLE_SIZE)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             hold,
  shiprr_req_if.sink            req,
  output logic                  q_valid,
  input  wire logic             q_ready,
  output logic                  q_op,
  output logic [SET_W-1:0]      q_set,
  output logic [WAY_W-1:0]      q_way,
  output logic [ADDR_W-1:0]     q_addr,
  output logic [SIG_W-1:0]      q_sig,
  output logic                  q_hit
);

  localparam bit SIG_POW2 = ((2 ** SIG_W) == SIG_TABLE_SIZE);
  localparam int NDIG     = ADDR_W / 4;
  localparam int DIG_W    = $clog2(NDIG);
  localparam int R_W      = SIG_W + 1;

  typedef struct packed {
    logic              op;
    logic [SET_W-1:0]  set;
    logic [WAY_W-1:0]  way;
    logic [ADDR_W-1:0] addr;
    logic [SIG_W-1:0]  sig;
    logic              hit;
  } entry_t;

  function automatic logic [SET_W-1:0] set_reduce(input logic [SETIN_W-1:0] v);
    logic [SETIN_W-1:0] t;
    t = v;
    for (int k = SETIN_W - 1; k >= 0; k--) begin
      if ((longint'(NUM_SETS) << k) < (longint'(1) << SETIN_W)) begin
        if (longint'(t) >= (longint'(NUM_SETS) << k)) begin
          t = t - SETIN_W'(longint'(NUM_SETS) << k);
        end
      end
    end
    return SET_W'(t);
  endfunction

  function automatic logic [WAY_W-1:0] way_reduce(input logic [WAYIN_W-1:0] v);
    logic [WAYIN_W-1:0] t;
    t = v;
    for (int k = WAYIN_W - 1; k >= 0; k--) begin
      if ((longint'(NUM_WAYS) << k) < (longint'(1) << WAYIN_W)) begin
        if (longint'(t) >= (longint'(NUM_WAYS) << k)) begin
          t = t - WAYIN_W'(longint'(NUM_WAYS) << k);
        end
      end
    end
    return WAY_W'(t);
  endfunction

  // One bit of a restoring remainder: shift in the bit, subtract the table size if reached.
  function automatic logic [SIG_W-1:0] mod_step(input logic [SIG_W-1:0] r, input logic b);
    logic [R_W-1:0] t;
    t = {r, b};
    if (t >= R_W'(SIG_TABLE_SIZE)) begin
      t = t - R_W'(SIG_TABLE_SIZE);
    end
    return SIG_W'(t);
  endfunction

  entry_t             fifo_mem [2];
  logic               wptr;
  logic               rptr;
  logic [1:0]         count;
  logic               busy;
  logic [DIG_W-1:0]   dig_cnt;
  logic [ADDR_W-1:0]  h_sh;
  logic [SIG_W-1:0]   rem;
  logic [SIG_W-1:0]   rem_next;
  entry_t             pend;
  entry_t             in_entry;
  entry_t             push_data;
  logic [ADDR_W-1:0]  hash;
  logic               acc;
  logic               push;
  logic               pop;
  entry_t             head;

  assign req.ready = !hold && !busy && (count != 2'd2);
  assign acc       = req.valid && req.ready;
  assign hash      = (req.pc >> HASH_SH_LO) ^ (req.pc >> HASH_SH_HI);

  always_comb begin
    in_entry.op   = req.op;
    in_entry.set  = set_reduce(req.set_index);
    in_entry.way  = way_reduce(req.way_index);
    in_entry.addr = req.phys_addr;
    in_entry.sig  = hash[SIG_W-1:0];
    in_entry.hit  = req.hit;
  end

  always_comb begin
    rem_next = rem;
    for (int i = 0; i < 4; i++) begin
      rem_next = mod_step(rem_next, h_sh[ADDR_W-1-i]);
    end
  end

  always_comb begin
    if (SIG_POW2) begin
      push      = acc;
      push_data = in_entry;
    end else begin
      push          = busy && (dig_cnt == DIG_W'(NDIG - 1));
      push_data     = pend;
      push_data.sig = rem_next;
    end
  end

  assign q_valid = (count != 2'd0);
  assign pop     = q_valid && q_ready;
  assign head    = fifo_mem[rptr];
  assign q_op    = head.op;
  assign q_set   = head.set;
  assign q_way   = head.way;
  assign q_addr  = head.addr;
  assign q_sig   = head.sig;
  assign q_hit   = head.hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr    <= 1'b0;
      rptr    <= 1'b0;
      count   <= 2'd0;
      busy    <= 1'b0;
      dig_cnt <= '0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
      if (!SIG_POW2 && acc) begin
        busy    <= 1'b1;
        dig_cnt <= '0;
      end else if (busy) begin
        dig_cnt <= dig_cnt + 1'b1;
        if (push) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // The hash is reduced four bits a cycle when the table size is not a power of two.
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wptr] <= push_data;
    end
    if (acc) begin
      pend <= in_entry;
      h_sh <= hash;
      rem  <= '0;
    end else if (busy) begin
      h_sh <= h_sh << 4;
      rem  <= rem_next;
    end
  end

endmodule
`default_nettype wire

// ===== src/shiprr_back.sv =====
`default_nettype none
module shiprr_back import shiprr_pkg::*; #(
  parameter int NUM_SETS       = DEF_NUM_SETS,
  parameter int NUM_WAYS       = DEF_NUM_WAYS,
  parameter int SIG_TABLE_SIZE = DEF_SIG_SIZE,
  localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1,
  localparam int WAY_W = $clog2(NUM_WAYS),
  localparam int SIG_W = $clog2(SIG_TABLE_SIZE)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  output logic                  clearing,
  input  wire logic             cfg_we,
  input  wire logic [THR_W-1:0] cfg_wdata,
  input  wire logic             q_valid,
  output logic                  q_ready,
  input  wire logic             q_op,
  input  wire logic [SET_W-1:0] q_set,
  input  wire logic [WAY_W-1:0] q_way,
  input  wire logic [ADDR_W-1:0] q_addr,
  input  wire logic [SIG_W-1:0] q_sig,
  input  wire logic             q_hit,
  shiprr_rsp_if.source          rsp
);

  localparam int CLR_N  = (NUM_SETS > SIG_TABLE_SIZE) ? NUM_SETS : SIG_TABLE_SIZE;
  localparam int CLR_W  = $clog2(CLR_N + 1);
  localparam int ROW_W  = NUM_WAYS * RRPV_W;
  localparam int SROW_W = NUM_WAYS * SIG_W;
  localparam int DET_W  = ADDR_W + STRIDE_W + SCORE_W;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_RD2   = 5'b00100,
    ST_EXEC  = 5'b01000,
    ST_SPARE = 5'b10000
  } state_t;

  logic [ROW_W-1:0]  rrpv_mem [NUM_SETS];
  logic [SROW_W-1:0] sig_mem  [NUM_SETS];
  logic [DET_W-1:0]  det_mem  [NUM_SETS];
  logic [CTR_W-1:0]  ctr_mem  [SIG_TABLE_SIZE];

  state_t            state;
  state_t            state_next;
  logic [CLR_W-1:0]  clr_cnt;
  logic [THR_W-1:0]  thresh;
  logic              cur_op;
  logic [SET_W-1:0]  cur_set;
  logic [WAY_W-1:0]  cur_way;
  logic [ADDR_W-1:0] cur_addr;
  logic [SIG_W-1:0]  cur_sig;
  logic              cur_hit;
  logic [ROW_W-1:0]  rrpv_rd;
  logic [SROW_W-1:0] sig_rd;
  logic [DET_W-1:0]  det_rd;
  logic [CTR_W-1:0]  ctr_a;
  logic [CTR_W-1:0]  ctr_b;
  logic              out_valid;
  logic [VICT_W-1:0] out_victim;
  logic              out_stream;

  logic              pop;
  logic              exec_fire;
  logic [SIG_W-1:0]  old_sig;
  logic [RRPV_W-1:0] top;
  logic [RRPV_W-1:0] add;
  logic [WAY_W-1:0]  vic_idx;
  logic              found;
  logic [ROW_W-1:0]  vic_row;
  logic [ADDR_W-1:0] prev_addr;
  logic [STRIDE_W-1:0] prev_stride;
  logic [SCORE_W-1:0] score;
  logic [STRIDE_W-1:0] stride;
  logic [STRIDE_W-1:0] stride_n;
  logic [SCORE_W-1:0] score_n;
  logic              streaming;
  logic [RRPV_W-1:0] ins_rrpv;
  logic [ROW_W-1:0]  upd_row;
  logic [SROW_W-1:0] upd_sig_row;
  logic              set_we;
  logic              sig_we;
  logic              det_we;
  logic [SET_W-1:0]  set_wa;
  logic [ROW_W-1:0]  rrpv_wd;
  logic [SROW_W-1:0] sig_wd;
  logic [DET_W-1:0]  det_wd;
  logic              ctr_we;
  logic [SIG_TABLE_SIZE > 1 ? SIG_W-1 : 0:0] ctr_wa;
  logic [CTR_W-1:0]  ctr_wd;

  assign clearing = (state == ST_CLEAR);
  assign q_ready  = (state == ST_IDLE);
  assign pop      = q_valid && q_ready;
  assign exec_fire = (state == ST_EXEC) && (!out_valid || rsp.ready);
  assign old_sig  = sig_rd[cur_way * SIG_W +: SIG_W];

  assign rsp.valid         = out_valid;
  assign rsp.victim_way    = out_victim;
  assign rsp.set_streaming = out_stream;

  // Victim: the set is aged by the gap between its oldest line and the maximum value.
  always_comb begin
    logic any3, any2, any1;
    any3 = 1'b0;
    any2 = 1'b0;
    any1 = 1'b0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      any3 = any3 | (rrpv_rd[w*RRPV_W +: RRPV_W] == 2'd3);
      any2 = any2 | (rrpv_rd[w*RRPV_W +: RRPV_W] == 2'd2);
      any1 = any1 | (rrpv_rd[w*RRPV_W +: RRPV_W] == 2'd1);
    end
    top = any3 ? 2'd3 : (any2 ? 2'd2 : (any1 ? 2'd1 : 2'd0));
    add = RRPV_MAX - top;
    vic_idx = '0;
    found = 1'b0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      vic_row[w*RRPV_W +: RRPV_W] = rrpv_rd[w*RRPV_W +: RRPV_W] + add;
      if (!found && (rrpv_rd[w*RRPV_W +: RRPV_W] == top)) begin
        found = 1'b1;
        vic_idx = WAY_W'(w);
      end
    end
  end

  // Stride detector, on 64-byte block numbers; only the low eight bits of the difference count.
  always_comb begin
    prev_addr   = det_rd[DET_W-1 -: ADDR_W];
    prev_stride = det_rd[SCORE_W +: STRIDE_W];
    score       = det_rd[SCORE_W-1:0];
    if (prev_addr != '0) begin
      stride = cur_addr[BLOCK_SHIFT +: STRIDE_W] - prev_addr[BLOCK_SHIFT +: STRIDE_W];
    end else begin
      stride = '0;
    end
    if ((stride != '0) && (stride == prev_stride)) begin
      stride_n = prev_stride;
      score_n  = (score == SCORE_MAX) ? score : score + 1'b1;
    end else begin
      stride_n = stride;
      score_n  = '0;
    end
    streaming = (score_n >= thresh);
  end

  always_comb begin
    if (cur_hit) begin
      ins_rrpv = RRPV_NEAR;
    end else if (streaming) begin
      ins_rrpv = RRPV_MAX;
    end else if (ctr_a >= CTR_STRONG) begin
      ins_rrpv = RRPV_NEAR;
    end else if (ctr_a == CTR_RESET) begin
      ins_rrpv = RRPV_LONG;
    end else begin
      ins_rrpv = RRPV_MAX;
    end
    upd_row = rrpv_rd;
    upd_row[cur_way*RRPV_W +: RRPV_W] = ins_rrpv;
    upd_sig_row = sig_rd;
    upd_sig_row[cur_way*SIG_W +: SIG_W] = cur_sig;
  end

  always_comb begin
    if (clearing) begin
      set_we  = (longint'(clr_cnt) < longint'(NUM_SETS));
      sig_we  = set_we;
      det_we  = set_we;
      set_wa  = clr_cnt[SET_W-1:0];
      rrpv_wd = {NUM_WAYS{RRPV_MAX}};
      sig_wd  = '0;
      det_wd  = '0;
      ctr_we  = (longint'(clr_cnt) < longint'(SIG_TABLE_SIZE));
      ctr_wa  = clr_cnt[SIG_W-1:0];
      ctr_wd  = CTR_RESET;
    end else begin
      set_we  = exec_fire;
      sig_we  = exec_fire && (cur_op == OP_UPDATE) && !cur_hit;
      det_we  = exec_fire && (cur_op == OP_UPDATE);
      set_wa  = cur_set;
      rrpv_wd = (cur_op == OP_UPDATE) ? upd_row : vic_row;
      sig_wd  = upd_sig_row;
      det_wd  = {cur_addr, stride_n, score_n};
      ctr_we  = exec_fire && (cur_op == OP_UPDATE);
      ctr_wa  = old_sig;
      if (cur_hit) begin
        ctr_wd = (ctr_b == CTR_MAX) ? ctr_b : ctr_b + 1'b1;
      end else begin
        ctr_wd = (ctr_b == '0) ? ctr_b : ctr_b - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (set_we) begin
      rrpv_mem[set_wa] <= rrpv_wd;
    end
    if (sig_we) begin
      sig_mem[set_wa] <= sig_wd;
    end
    if (det_we) begin
      det_mem[set_wa] <= det_wd;
    end
    if (pop) begin
      rrpv_rd <= rrpv_mem[q_set];
      sig_rd  <= sig_mem[q_set];
      det_rd  <= det_mem[q_set];
    end
  end

  // The counter of the stored signature is read in the ST_RD2 state, once the set row is in.
  always_ff @(posedge clk) begin
    if (ctr_we) begin
      ctr_mem[ctr_wa] <= ctr_wd;
    end
    if (pop) begin
      ctr_a <= ctr_mem[q_sig];
    end
    if (state == ST_RD2) begin
      ctr_b <= ctr_mem[old_sig];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_op   <= q_op;
      cur_set  <= q_set;
      cur_way  <= q_way;
      cur_addr <= q_addr;
      cur_sig  <= q_sig;
      cur_hit  <= q_hit;
    end
    if (exec_fire) begin
      out_victim <= (cur_op == OP_UPDATE) ? '0 : VICT_W'(vic_idx);
      out_stream <= (cur_op == OP_UPDATE) ? streaming : 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_cnt == CLR_W'(CLR_N - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          state_next = (q_op == OP_UPDATE) ? ST_RD2 : ST_EXEC;
        end
      end
      ST_RD2: begin
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (exec_fire) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      thresh    <= THR_RESET;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cfg_we) begin
        thresh <= cfg_wdata;
      end
      if (exec_fire) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/ship_rrip_streaming_bypass_replacer_unit.sv =====
`default_nettype none
// Cache replacement engine: 2-bit RRIP per line, outcome counters indexed by a
// hashed PC signature, and a stride detector per set that forces distant
// insertion in streaming sets. After reset the block sweeps its tables over
// max(NUM_SETS, SIG_TABLE_SIZE) entries (4096 by default) and accepts no word
// meanwhile; the threshold register may be written at any idle time. A victim
// request goes through a set row read and an age and write back in the back
// end, and an update through a set row read, a read of the counter addressed
// by the line's stored signature and a write back. When SIG_TABLE_SIZE is not
// a power of two the front end reduces the hash four bits at a time. A
// two-word queue separates the front end from the back end, and the result
// register lets the next word start while a result waits to be taken.
module ship_rrip_streaming_bypass_replacer_unit import shiprr_pkg::*; #(
  parameter int NUM_SETS       = DEF_NUM_SETS,
  parameter int NUM_WAYS       = DEF_NUM_WAYS,
  parameter int SIG_TABLE_SIZE = DEF_SIG_SIZE
) (
  input  wire logic             clk,
  input  wire logic             rst,
  shiprr_req_if.sink            req,
  shiprr_rsp_if.source          rsp,
  input  wire logic             cfg_we,
  input  wire logic [THR_W-1:0] cfg_wdata
);

  localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int WAY_W = $clog2(NUM_WAYS);
  localparam int SIG_W = $clog2(SIG_TABLE_SIZE);

  logic              clearing;
  logic              q_valid;
  logic              q_ready;
  logic              q_op;
  logic [SET_W-1:0]  q_set;
  logic [WAY_W-1:0]  q_way;
  logic [ADDR_W-1:0] q_addr;
  logic [SIG_W-1:0]  q_sig;
  logic              q_hit;

  shiprr_front #(
    .NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS), .SIG_TABLE_SIZE(SIG_TABLE_SIZE)
  ) u_front (
    .clk(clk), .rst(rst), .hold(clearing), .req(req),
    .q_valid(q_valid), .q_ready(q_ready), .q_op(q_op), .q_set(q_set),
    .q_way(q_way), .q_addr(q_addr), .q_sig(q_sig), .q_hit(q_hit)
  );

  shiprr_back #(
    .NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS), .SIG_TABLE_SIZE(SIG_TABLE_SIZE)
  ) u_back (
    .clk(clk), .rst(rst), .clearing(clearing),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .q_valid(q_valid), .q_ready(q_ready), .q_op(q_op), .q_set(q_set),
    .q_way(q_way), .q_addr(q_addr), .q_sig(q_sig), .q_hit(q_hit),
    .rsp(rsp)
  );

endmodule
`default_nettype wire

// ===== src/shiprr_checker.sv =====
`default_nettype none
module shiprr_checker import shiprr_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              req_ready,
  input wire logic              rsp_valid,
  input wire logic              rsp_ready,
  input wire logic [VICT_W-1:0] victim_way,
  input wire logic              set_streaming
);

  // A pending result is not withdrawn before it is taken.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  // A victim word never reports streaming and an update word never names a way.
  a_rsp_kind: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !((victim_way != '0) && set_streaming))
    else $error("result mixes victim and update fields");

  a_rst_rsp: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result present straight after reset");

  // The table sweep keeps the input closed after reset.
  a_rst_sweep: assert property (@(posedge clk)
    rst |=> !req_ready)
    else $error("input open during table sweep");

endmodule

bind ship_rrip_streaming_bypass_replacer_unit shiprr_checker u_shiprr_checker (
  .clk(clk), .rst(rst), .req_ready(req.ready), .rsp_valid(rsp.valid),
  .rsp_ready(rsp.ready), .victim_way(rsp.victim_way),
  .set_streaming(rsp.set_streaming)
);
`default_nettype wire
